// File: src/mmbbc_pkg.sv
// Shared types and constants for the meter map bar/beat converter.
// Used by the divider, the top level and the checker.
`default_nettype none
package mmbbc_pkg;

	localparam int MAX_CHANGES = 64;
	localparam int ADDR_W      = $clog2(MAX_CHANGES);
	localparam int CNT_W       = $clog2(MAX_CHANGES + 1);

	localparam int TICK_W = 48;
	localparam int NUM_W  = 8;
	localparam int POW_W  = 4;
	localparam int TPQ_W  = 16;
	localparam int BL_W   = 18;
	localparam int BT_W   = 26;
	localparam int SUM_W  = 60;
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 26;
	localparam int DIV_CNT_W = $clog2(TICK_W);

	localparam logic [TPQ_W-1:0] TPQ_RESET   = 16'd480;
	localparam logic [NUM_W-1:0] DEFAULT_NUM = 8'd4;
	localparam logic [POW_W-1:0] DEFAULT_POW = 4'd2;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_CLEAR  = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_B2T    = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [TICK_W-1:0] tick;
		logic [NUM_W-1:0]  num;
		logic [POW_W-1:0]  pow;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              start;
		logic [TICK_W-1:0] dividend;
		logic [BT_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [TICK_W-1:0] quotient;
		logic [BT_W-1:0]   remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

// File: src/meter_map_bar_beat_converter.sv
// Top level of the meter map bar/beat converter: sequencer around the change table.
// Depends on mmbbc_pkg, mmbbc_ram (change table) and mmbbc_div (shared divider).
`default_nettype none
// One request is worked on at a time; a finished result waits in the output
// register while the next request is taken. After reset the block writes the
// 4/4 entry at tick 0 in its init state before it takes a request. Add and
// remove scan the table with a read and a compare state per entry and then
// shift entries one place at a time, with a read and a write state for each.
// Query and bar/beat conversion walk the table segment by segment; every segment
// passed costs one run of the divider, and a query adds up to a second divider
// run at the end. The divider and the single read port of the table set the pace.
module meter_map_bar_beat_converter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [mmbbc_pkg::TPQ_W-1:0] cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [2:0]                  opcode,
	input  wire logic [47:0]                 tick,
	input  wire logic [7:0]                  numerator,
	input  wire logic [3:0]                  denominator_pow2,
	input  wire logic signed [31:0]          bar_number,
	input  wire logic signed [31:0]          beat_number,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic [7:0]                       sig_numerator,
	output logic [15:0]                      sig_denominator,
	output logic [17:0]                      beat_length,
	output logic [25:0]                      bar_length,
	output logic [47:0]                      bar_index,
	output logic [14:0]                      beat_index,
	output logic [17:0]                      tick_in_beat,
	output logic [47:0]                      tick_result,
	output logic                             overflow
);

	localparam int SW = 5;
	localparam logic [SW-1:0] S_INIT     = 5'd0;
	localparam logic [SW-1:0] S_IDLE     = 5'd1;
	localparam logic [SW-1:0] S_DISP     = 5'd2;
	localparam logic [SW-1:0] S_FIND_RD  = 5'd3;
	localparam logic [SW-1:0] S_FIND_CMP = 5'd4;
	localparam logic [SW-1:0] S_ADD_RD   = 5'd5;
	localparam logic [SW-1:0] S_ADD_CMP  = 5'd6;
	localparam logic [SW-1:0] S_REM_RD   = 5'd7;
	localparam logic [SW-1:0] S_REM_WR   = 5'd8;
	localparam logic [SW-1:0] S_W_RD     = 5'd9;
	localparam logic [SW-1:0] S_W_LD     = 5'd10;
	localparam logic [SW-1:0] S_W_LEN    = 5'd11;
	localparam logic [SW-1:0] S_W_BT     = 5'd12;
	localparam logic [SW-1:0] S_W_SEG    = 5'd13;
	localparam logic [SW-1:0] S_W_ACC    = 5'd14;
	localparam logic [SW-1:0] S_Q_DIV1   = 5'd15;
	localparam logic [SW-1:0] S_Q_DIV2   = 5'd16;
	localparam logic [SW-1:0] S_B_MUL1   = 5'd17;
	localparam logic [SW-1:0] S_B_MUL2   = 5'd18;
	localparam logic [SW-1:0] S_B_SUM    = 5'd19;
	localparam logic [SW-1:0] S_DONE     = 5'd20;

	logic [SW-1:0] state_q;

	logic [mmbbc_pkg::TPQ_W-1:0]  tpq_q;
	logic [mmbbc_pkg::CNT_W-1:0]  cnt_q;
	logic [mmbbc_pkg::CNT_W-1:0]  idx_q;
	logic [2:0]                   op_q;
	logic [mmbbc_pkg::TICK_W-1:0] tick_q;
	logic [mmbbc_pkg::NUM_W-1:0]  num_q;
	logic [mmbbc_pkg::POW_W-1:0]  pow_q;
	logic [31:0]                  bar_q;
	logic [31:0]                  beat_q;
	logic [1:0]                   wstat_q;
	mmbbc_pkg::entry_t            cur_q;
	mmbbc_pkg::entry_t            nxt_q;
	logic [mmbbc_pkg::TICK_W-1:0] acc_q;
	logic [mmbbc_pkg::BL_W-1:0]   bl_q;
	logic [mmbbc_pkg::BT_W-1:0]   bt_q;
	logic [mmbbc_pkg::TICK_W-1:0] bidx_q;
	logic [14:0]                  beat_idx_q;
	logic [mmbbc_pkg::BL_W-1:0]   tib_q;
	logic [mmbbc_pkg::SUM_W-1:0]  prod_q;
	logic [mmbbc_pkg::SUM_W-1:0]  sum_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [7:0]  sig_num_q;
	logic [15:0] sig_den_q;
	logic [17:0] beat_len_q;
	logic [25:0] bar_len_q;
	logic [47:0] bar_idx_q;
	logic [14:0] beat_out_q;
	logic [17:0] tib_out_q;
	logic [47:0] tres_q;
	logic        ovf_q;

	logic                          ram_we;
	logic [mmbbc_pkg::ADDR_W-1:0]  ram_waddr;
	mmbbc_pkg::entry_t             ram_wdata;
	logic [mmbbc_pkg::ADDR_W-1:0]  ram_raddr;
	logic [mmbbc_pkg::ENTRY_W-1:0] ram_rdata;
	mmbbc_pkg::entry_t             rd_entry;
	mmbbc_pkg::entry_t             new_entry;
	mmbbc_pkg::entry_t             def_entry;

	mmbbc_pkg::div_req_t div_req;
	mmbbc_pkg::div_rsp_t div_rsp;

	logic [mmbbc_pkg::CNT_W-1:0]   idx_p1;
	logic [mmbbc_pkg::CNT_W-1:0]   idx_m1;
	logic                          last_seg;
	logic                          hit;
	logic [mmbbc_pkg::BL_W-1:0]    tpq4;
	logic [mmbbc_pkg::BT_W-1:0]    bt_raw;
	logic [31:0]                   bar_left;
	logic [mmbbc_pkg::MUL_A_W-1:0] mul_a;
	logic [mmbbc_pkg::MUL_B_W-1:0] mul_b;
	logic [mmbbc_pkg::SUM_W-1:0]   mul_p;
	logic [mmbbc_pkg::BL_W-1:0]    bl_nz;
	logic                          out_free;
	logic                          is_query;
	logic                          is_b2t;
	logic                          b2t_ovf;

	mmbbc_ram #(
		.WIDTH(mmbbc_pkg::ENTRY_W),
		.DEPTH(mmbbc_pkg::MAX_CHANGES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	mmbbc_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_comb begin
		rd_entry  = mmbbc_pkg::entry_t'(ram_rdata);
		new_entry = '{tick: tick_q, num: num_q, pow: pow_q};
		def_entry = '{tick: '0, num: mmbbc_pkg::DEFAULT_NUM, pow: mmbbc_pkg::DEFAULT_POW};
		idx_p1    = idx_q + 1'b1;
		idx_m1    = idx_q - 1'b1;
		last_seg  = (idx_p1 >= cnt_q);
		hit       = (rd_entry.tick == tick_q);
		tpq4      = {tpq_q, 2'b00};
		bt_raw    = mmbbc_pkg::BT_W'(bl_q * cur_q.num);
		bar_left  = bar_q - acc_q[31:0];
		bl_nz     = (bl_q == '0) ? mmbbc_pkg::BL_W'(1) : bl_q;
		out_free  = !out_valid_q || out_ready;
		is_query  = (op_q == mmbbc_pkg::OP_QUERY);
		is_b2t    = (op_q == mmbbc_pkg::OP_B2T);
		b2t_ovf   = is_b2t && (sum_q[mmbbc_pkg::SUM_W-1:mmbbc_pkg::TICK_W] != '0);
	end

	// Table port and divider requests follow the sequencer state.
	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = idx_q[mmbbc_pkg::ADDR_W-1:0];
		ram_wdata    = new_entry;
		ram_raddr    = idx_q[mmbbc_pkg::ADDR_W-1:0];
		div_req      = '0;
		mul_a        = bar_left;
		mul_b        = bt_q;
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = def_entry;
			end
			S_DISP: begin
				if (op_q == mmbbc_pkg::OP_CLEAR) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = def_entry;
				end
			end
			S_FIND_CMP: begin
				ram_we = hit && (op_q == mmbbc_pkg::OP_ADD);
			end
			S_ADD_RD: begin
				ram_raddr = idx_m1[mmbbc_pkg::ADDR_W-1:0];
				ram_we    = (idx_q == '0);
			end
			S_ADD_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = (rd_entry.tick > tick_q) ? rd_entry : new_entry;
			end
			S_REM_RD: begin
				ram_raddr = idx_p1[mmbbc_pkg::ADDR_W-1:0];
			end
			S_REM_WR: begin
				ram_we    = 1'b1;
				ram_wdata = rd_entry;
			end
			S_W_LD: begin
				ram_raddr = idx_p1[mmbbc_pkg::ADDR_W-1:0];
			end
			S_W_SEG: begin
				div_req.divisor = bt_q;
				if (op_q == mmbbc_pkg::OP_QUERY) begin
					div_req.start = 1'b1;
					if (last_seg || (nxt_q.tick > tick_q)) begin
						div_req.dividend = tick_q - cur_q.tick;
					end else begin
						div_req.dividend = nxt_q.tick - cur_q.tick;
					end
				end else begin
					div_req.start    = !last_seg;
					div_req.dividend = nxt_q.tick - cur_q.tick;
				end
			end
			S_Q_DIV1: begin
				div_req.start    = div_rsp.done && (bl_q != '0);
				div_req.dividend = mmbbc_pkg::TICK_W'(div_rsp.remainder);
				div_req.divisor  = mmbbc_pkg::BT_W'(bl_q);
			end
			S_B_MUL2: begin
				mul_a = beat_q;
				mul_b = mmbbc_pkg::MUL_B_W'(bl_nz);
			end
			default: begin
			end
		endcase
		mul_p = mmbbc_pkg::SUM_W'(mul_a) * mmbbc_pkg::SUM_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			tpq_q       <= mmbbc_pkg::TPQ_RESET;
			cnt_q       <= mmbbc_pkg::CNT_W'(1);
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tpq_q <= cfg_data;
			end
			// A new result may replace one that leaves in the same cycle.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						tick_q  <= tick;
						num_q   <= numerator;
						pow_q   <= denominator_pow2;
						bar_q   <= bar_number[31] ? '0 : bar_number;
						beat_q  <= beat_number[31] ? '0 : beat_number;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					idx_q   <= '0;
					acc_q   <= '0;
					unique case (op_q)
						mmbbc_pkg::OP_ADD: begin
							wstat_q <= mmbbc_pkg::ST_OK;
							state_q <= S_FIND_RD;
						end
						mmbbc_pkg::OP_REMOVE: begin
							if (tick_q == '0) begin
								wstat_q <= mmbbc_pkg::ST_REFUSED;
								state_q <= S_DONE;
							end else begin
								wstat_q <= mmbbc_pkg::ST_OK;
								state_q <= S_FIND_RD;
							end
						end
						mmbbc_pkg::OP_CLEAR: begin
							wstat_q <= mmbbc_pkg::ST_OK;
							cnt_q   <= mmbbc_pkg::CNT_W'(1);
							state_q <= S_DONE;
						end
						mmbbc_pkg::OP_QUERY, mmbbc_pkg::OP_B2T: begin
							wstat_q <= mmbbc_pkg::ST_OK;
							state_q <= S_W_RD;
						end
						default: begin
							wstat_q <= mmbbc_pkg::ST_REFUSED;
							state_q <= S_DONE;
						end
					endcase
				end
				S_FIND_RD: begin
					state_q <= S_FIND_CMP;
				end
				S_FIND_CMP: begin
					if (hit) begin
						state_q <= (op_q == mmbbc_pkg::OP_ADD) ? S_DONE : S_REM_RD;
					end else if (idx_p1 == cnt_q) begin
						if (op_q != mmbbc_pkg::OP_ADD) begin
							wstat_q <= mmbbc_pkg::ST_REFUSED;
							state_q <= S_DONE;
						end else if (cnt_q == mmbbc_pkg::CNT_W'(mmbbc_pkg::MAX_CHANGES)) begin
							wstat_q <= mmbbc_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							idx_q   <= cnt_q;
							state_q <= S_ADD_RD;
						end
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_FIND_RD;
					end
				end
				S_ADD_RD: begin
					if (idx_q == '0) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ADD_CMP;
					end
				end
				S_ADD_CMP: begin
					// Entries above the new tick move up by one place.
					if (rd_entry.tick > tick_q) begin
						idx_q   <= idx_m1;
						state_q <= S_ADD_RD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_REM_RD: begin
					if (last_seg) begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_REM_WR;
					end
				end
				S_REM_WR: begin
					idx_q   <= idx_p1;
					state_q <= S_REM_RD;
				end
				S_W_RD: begin
					state_q <= S_W_LD;
				end
				S_W_LD: begin
					cur_q   <= rd_entry;
					state_q <= S_W_LEN;
				end
				S_W_LEN: begin
					nxt_q   <= rd_entry;
					bl_q    <= tpq4 >> cur_q.pow;
					state_q <= S_W_BT;
				end
				S_W_BT: begin
					bt_q    <= (bt_raw == '0) ? mmbbc_pkg::BT_W'(tpq4) : bt_raw;
					state_q <= S_W_SEG;
				end
				S_W_SEG: begin
					if (op_q == mmbbc_pkg::OP_QUERY) begin
						state_q <= (last_seg || (nxt_q.tick > tick_q)) ? S_Q_DIV1 : S_W_ACC;
					end else begin
						state_q <= last_seg ? S_B_MUL1 : S_W_ACC;
					end
				end
				S_W_ACC: begin
					if (div_rsp.done) begin
						if (op_q == mmbbc_pkg::OP_QUERY) begin
							acc_q   <= acc_q + div_rsp.quotient;
							idx_q   <= idx_p1;
							state_q <= S_W_RD;
						end else if ({16'b0, bar_left} >= div_rsp.quotient) begin
							acc_q   <= acc_q + div_rsp.quotient;
							idx_q   <= idx_p1;
							state_q <= S_W_RD;
						end else begin
							state_q <= S_B_MUL1;
						end
					end
				end
				S_Q_DIV1: begin
					if (div_rsp.done) begin
						bidx_q <= acc_q + div_rsp.quotient;
						if (bl_q == '0) begin
							beat_idx_q <= '0;
							tib_q      <= div_rsp.remainder[mmbbc_pkg::BL_W-1:0];
							state_q    <= S_DONE;
						end else begin
							state_q <= S_Q_DIV2;
						end
					end
				end
				S_Q_DIV2: begin
					if (div_rsp.done) begin
						beat_idx_q <= div_rsp.quotient[14:0];
						tib_q      <= div_rsp.remainder[mmbbc_pkg::BL_W-1:0];
						state_q    <= S_DONE;
					end
				end
				S_B_MUL1: begin
					prod_q  <= mul_p;
					state_q <= S_B_MUL2;
				end
				S_B_MUL2: begin
					sum_q   <= mmbbc_pkg::SUM_W'(cur_q.tick) + prod_q;
					prod_q  <= mul_p;
					state_q <= S_B_SUM;
				end
				S_B_SUM: begin
					sum_q   <= sum_q + prod_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						status_q   <= wstat_q;
						sig_num_q  <= is_query ? cur_q.num : '0;
						sig_den_q  <= is_query ? (16'd1 << cur_q.pow) : '0;
						beat_len_q <= is_query ? bl_q : '0;
						bar_len_q  <= is_query ? bt_q : '0;
						bar_idx_q  <= is_query ? bidx_q : '0;
						beat_out_q <= is_query ? beat_idx_q : '0;
						tib_out_q  <= is_query ? tib_q : '0;
						if (!is_b2t) begin
							tres_q <= '0;
						end else if (b2t_ovf) begin
							tres_q <= '1;
						end else begin
							tres_q <= sum_q[mmbbc_pkg::TICK_W-1:0];
						end
						ovf_q   <= b2t_ovf;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready       = 1'b1;
	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign sig_numerator   = sig_num_q;
	assign sig_denominator = sig_den_q;
	assign beat_length     = beat_len_q;
	assign bar_length      = bar_len_q;
	assign bar_index       = bar_idx_q;
	assign beat_index      = beat_out_q;
	assign tick_in_beat    = tib_out_q;
	assign tick_result     = tres_q;
	assign overflow        = ovf_q;

endmodule
`default_nettype wire

// File: src/mmbbc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module mmbbc_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: src/mmbbc_div.sv
// Restoring divider, one quotient bit per cycle: 48-bit dividend, 26-bit divisor.
// Depends on mmbbc_pkg for widths and the request/response structs.
`default_nettype none
module mmbbc_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mmbbc_pkg::div_req_t req,
	output mmbbc_pkg::div_rsp_t      rsp
);

	logic [mmbbc_pkg::TICK_W-1:0]    quot_q;
	logic [mmbbc_pkg::BT_W-1:0]      rem_q;
	logic [mmbbc_pkg::BT_W-1:0]      dvs_q;
	logic [mmbbc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [mmbbc_pkg::BT_W:0] trial;
	logic [mmbbc_pkg::BT_W:0] diff;
	logic                     ge;

	always_comb begin
		trial = {rem_q, quot_q[mmbbc_pkg::TICK_W-1]};
		ge    = (trial >= {1'b0, dvs_q});
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				rem_q  <= ge ? diff[mmbbc_pkg::BT_W-1:0] : trial[mmbbc_pkg::BT_W-1:0];
				quot_q <= {quot_q[mmbbc_pkg::TICK_W-2:0], ge};
				if (cnt_q == mmbbc_pkg::DIV_CNT_W'(mmbbc_pkg::TICK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end else if (req.start) begin
				quot_q <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quot_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

// File: src/mmbbc_checker.sv
// Port-level checks for the meter map bar/beat converter, bound to the top level.
// Depends on the top level's ports and on mmbbc_pkg for the status codes.
`default_nettype none
module mmbbc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [47:0] bar_index,
	input wire logic [47:0] tick_result,
	input wire logic        overflow
);

	// A waiting result keeps its status and tick result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(tick_result))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= mmbbc_pkg::ST_FULL)
		else $error("undefined status code");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> tick_result == 48'hFFFF_FFFF_FFFF)
		else $error("overflow without saturated tick");

	// A refused or full request carries no position or tick.
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mmbbc_pkg::ST_OK |->
			bar_index == '0 && tick_result == '0 && !overflow)
		else $error("refused request carries data");

endmodule

bind meter_map_bar_beat_converter mmbbc_checker u_mmbbc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.bar_index  (bar_index),
	.tick_result(tick_result),
	.overflow   (overflow)
);
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the meter map bar/beat converter.
// Depends on mmbbc_pkg and meter_map_bar_beat_converter; holds its own predictor of the block.
`timescale 1ns / 100ps
module tb_top;

	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_MID = 3'd6;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;
	localparam int STALL_LIMIT = 40000;
	localparam longint unsigned TICK_MAX = 64'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [2:0]         op;
		logic [47:0]        tk;
		logic [7:0]         num;
		logic [3:0]         pow;
		logic signed [31:0] bar;
		logic signed [31:0] beat;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  snum;
		logic [15:0] sden;
		logic [17:0] blen;
		logic [25:0] btlen;
		logic [47:0] bidx;
		logic [14:0] beidx;
		logic [17:0] tib;
		logic [47:0] tres;
		logic        ovf;
	} res_t;

	typedef struct {
		req_t r;
		bit   known;
		res_t want;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [mmbbc_pkg::TPQ_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] opcode = '0;
	logic [47:0] tick = '0;
	logic [7:0] numerator = '0;
	logic [3:0] denominator_pow2 = '0;
	logic signed [31:0] bar_number = '0;
	logic signed [31:0] beat_number = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] status;
	logic [7:0] sig_numerator;
	logic [15:0] sig_denominator;
	logic [17:0] beat_length;
	logic [25:0] bar_length;
	logic [47:0] bar_index;
	logic [14:0] beat_index;
	logic [17:0] tick_in_beat;
	logic [47:0] tick_result;
	logic overflow;

	meter_map_bar_beat_converter i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .tick(tick),
		.numerator(numerator), .denominator_pow2(denominator_pow2),
		.bar_number(bar_number), .beat_number(beat_number),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.sig_numerator(sig_numerator), .sig_denominator(sig_denominator),
		.beat_length(beat_length), .bar_length(bar_length), .bar_index(bar_index),
		.beat_index(beat_index), .tick_in_beat(tick_in_beat),
		.tick_result(tick_result), .overflow(overflow)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// Predictor state: the change table, its fill and the quarter-note resolution.
	logic [47:0] meter_tick [mmbbc_pkg::MAX_CHANGES];
	logic [7:0]  meter_num [mmbbc_pkg::MAX_CHANGES];
	logic [3:0]  meter_pow [mmbbc_pkg::MAX_CHANGES];
	int          meter_count;
	longint unsigned tpq_now;

	res_t     pending_results[$];
	dir_row_t dir_rows[$];
	int   mismatches = 0;
	bit   idle_on = 1;
	int   stall_left = 0;
	int   quiet_cycles = 0;

	function automatic longint unsigned beat_ticks(int i);
		return (tpq_now * 4) >> meter_pow[i];
	endfunction

	function automatic longint unsigned bar_ticks(int i);
		longint unsigned b;
		b = beat_ticks(i) * meter_num[i];
		return (b == 0) ? tpq_now * 4 : b;
	endfunction

	function automatic int find_change(logic [47:0] t);
		for (int i = 0; i < meter_count; i++)
			if (meter_tick[i] == t) return i;
		return -1;
	endfunction

	function automatic res_t meter_step(req_t r);
		res_t o;
		int k, i;
		longint unsigned bars, seg, nxt, bt, bl, off, in_bar, bar, beat, passed, in_seg, sum;
		o = '0;
		case (r.op)
			mmbbc_pkg::OP_ADD: begin
				k = find_change(r.tk);
				if (k >= 0) begin
					meter_num[k] = r.num;
					meter_pow[k] = r.pow;
				end else if (meter_count >= mmbbc_pkg::MAX_CHANGES) begin
					o.status = mmbbc_pkg::ST_FULL;
				end else begin
					i = meter_count;
					while (i > 0 && meter_tick[i-1] > r.tk) begin
						meter_tick[i] = meter_tick[i-1];
						meter_num[i] = meter_num[i-1];
						meter_pow[i] = meter_pow[i-1];
						i--;
					end
					meter_tick[i] = r.tk;
					meter_num[i] = r.num;
					meter_pow[i] = r.pow;
					meter_count++;
				end
			end
			mmbbc_pkg::OP_REMOVE: begin
				k = (r.tk == 0) ? -1 : find_change(r.tk);
				if (k < 0) begin
					o.status = mmbbc_pkg::ST_REFUSED;
				end else begin
					for (i = k; i + 1 < meter_count; i++) begin
						meter_tick[i] = meter_tick[i+1];
						meter_num[i] = meter_num[i+1];
						meter_pow[i] = meter_pow[i+1];
					end
					meter_count--;
				end
			end
			mmbbc_pkg::OP_CLEAR: begin
				meter_tick[0] = '0;
				meter_num[0] = mmbbc_pkg::DEFAULT_NUM;
				meter_pow[0] = mmbbc_pkg::DEFAULT_POW;
				meter_count = 1;
			end
			mmbbc_pkg::OP_QUERY: begin
				bars = 0;
				seg = 0;
				for (i = 0; i < meter_count; i++) begin
					nxt = (i + 1 < meter_count) ? meter_tick[i+1] : longint'(r.tk) + 1;
					bt = bar_ticks(i);
					if (nxt > r.tk) begin
						bl = beat_ticks(i);
						off = r.tk - seg;
						in_bar = off % bt;
						o.snum = meter_num[i];
						o.sden = 16'(1 << meter_pow[i]);
						o.blen = 18'(bl);
						o.btlen = 26'(bt);
						o.bidx = 48'(bars + off / bt);
						o.beidx = 15'((bl != 0) ? in_bar / bl : 0);
						o.tib = 18'((bl != 0) ? in_bar % bl : in_bar);
						break;
					end
					bars += (nxt - seg) / bt;
					seg = nxt;
				end
			end
			mmbbc_pkg::OP_B2T: begin
				// Negative bar or beat counts as zero.
				bar = r.bar[31] ? 0 : longint'(r.bar);
				beat = r.beat[31] ? 0 : longint'(r.beat);
				passed = 0;
				seg = 0;
				sum = 0;
				for (i = 0; i < meter_count; i++) begin
					bt = bar_ticks(i);
					bl = beat_ticks(i);
					if (bl == 0) bl = 1;
					if (i + 1 < meter_count) begin
						in_seg = (meter_tick[i+1] - seg) / bt;
						if (bar - passed >= in_seg) begin
							passed += in_seg;
							seg = meter_tick[i+1];
							continue;
						end
					end
					sum = seg + (bar - passed) * bt + beat * bl;
					break;
				end
				if (sum > TICK_MAX) begin
					o.tres = '1;
					o.ovf = 1'b1;
				end else begin
					o.tres = 48'(sum);
				end
			end
			default: o.status = mmbbc_pkg::ST_REFUSED;
		endcase
		return o;
	endfunction

	function automatic req_t mk(logic [2:0] op, logic [47:0] tk, logic [7:0] num,
			logic [3:0] pow, logic signed [31:0] bar, logic signed [31:0] beat);
		req_t r;
		r.op = op;
		r.tk = tk;
		r.num = num;
		r.pow = pow;
		r.bar = bar;
		r.beat = beat;
		return r;
	endfunction

	function automatic void add_row(req_t r, bit known, res_t want);
		dir_row_t row;
		row.r = r;
		row.known = known;
		row.want = want;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// Sends one request; the valid stays high into the next call unless a gap is inserted.
	task automatic send_request(req_t r, bit known = 0, res_t want = '0);
		res_t pred;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= r.op;
		tick <= r.tk;
		numerator <= r.num;
		denominator_pow2 <= r.pow;
		bar_number <= r.bar;
		beat_number <= r.beat;
		do @(posedge clk); while (!in_ready);
		pred = meter_step(r);
		pending_results.insert(pending_results.size(), known ? want : pred);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_tpq(logic [mmbbc_pkg::TPQ_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tpq_now = v;
	endtask

	function automatic logic [47:0] pick_tick();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3 && meter_count > 1)
			return meter_tick[$urandom_range(1, meter_count - 1)];
		if (sel == 9)
			return 48'({$urandom(), $urandom()});
		return 48'($urandom_range(0, 200000));
	endfunction

	function automatic logic signed [31:0] pick_count();
		if ($urandom_range(0, 3) == 0) return $urandom();
		return $urandom_range(0, 3000) - 2;
	endfunction

	task automatic random_phase(int n);
		int w;
		req_t r;
		for (int j = 0; j < n; j++) begin
			r = mk(mmbbc_pkg::OP_QUERY, pick_tick(), 8'($urandom()), 4'($urandom()),
				pick_count(), pick_count());
			w = $urandom_range(0, 99);
			if (w < 30)
				r.op = (meter_count >= 16) ? mmbbc_pkg::OP_REMOVE : mmbbc_pkg::OP_ADD;
			else if (w < 45) r.op = mmbbc_pkg::OP_REMOVE;
			else if (w < 48) r.op = mmbbc_pkg::OP_CLEAR;
			else if (w < 72) r.op = mmbbc_pkg::OP_QUERY;
			else if (w < 97) r.op = mmbbc_pkg::OP_B2T;
			else r.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			send_request(r);
		end
	endtask

	// Fills the table to capacity, tries one more new tick, runs a query and a bar/beat conversion, then clears.
	task automatic fill_and_clear();
		while (meter_count < mmbbc_pkg::MAX_CHANGES)
			send_request(mk(mmbbc_pkg::OP_ADD, 48'($urandom_range(1, 1 << 20)),
				8'($urandom()), 4'($urandom()), 0, 0));
		send_request(mk(mmbbc_pkg::OP_ADD, 48'hFFFF_FFFF_FFFF, 8'd3, 4'd3, 0, 0));
		send_request(mk(mmbbc_pkg::OP_QUERY, 48'($urandom_range(0, 1 << 20)), 0, 0, 0, 0));
		send_request(mk(mmbbc_pkg::OP_B2T, 0, 0, 0, $urandom_range(0, 500), 2));
		send_request(mk(mmbbc_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
	endtask

	// Result side: random back-pressure and the comparison against the oldest expectation.
	always @(posedge clk) begin
		res_t got, want;
		if (out_valid && out_ready) begin
			got = '{status, sig_numerator, sig_denominator, beat_length, bar_length,
				bar_index, beat_index, tick_in_beat, tick_result, overflow};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.snum !== want.snum ||
						got.sden !== want.sden || got.blen !== want.blen ||
						got.btlen !== want.btlen || got.bidx !== want.bidx ||
						got.beidx !== want.beidx || got.tib !== want.tib ||
						got.tres !== want.tres || got.ovf !== want.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch\n  expected %p\n  actual   %p", want, got);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		res_t k;
		meter_tick[0] = '0;
		meter_num[0] = mmbbc_pkg::DEFAULT_NUM;
		meter_pow[0] = mmbbc_pkg::DEFAULT_POW;
		meter_count = 1;
		tpq_now = mmbbc_pkg::TPQ_RESET;

		// Reset state: 4/4 at 480 per quarter.
		k = '0;
		k.snum = 8'd4;
		k.sden = 16'd4;
		k.blen = 18'd480;
		k.btlen = 26'd1920;
		add_row(mk(mmbbc_pkg::OP_QUERY, 0, 0, 0, 0, 0), 1, k);
		k = '0;
		k.status = mmbbc_pkg::ST_REFUSED;
		add_row(mk(mmbbc_pkg::OP_REMOVE, 0, 0, 0, 0, 0), 1, k);
		add_row(mk(mmbbc_pkg::OP_REMOVE, 48'd5, 0, 0, 0, 0), 1, k);
		add_row(mk(OP_SPARE_LO, '1, '1, '1, -1, -1), 1, k);
		add_row(mk(OP_SPARE_MID, 0, 0, 0, 0, 0), 1, k);
		add_row(mk(OP_SPARE_HI, 0, 0, 0, 0, 0), 1, k);
		k = '0;
		add_row(mk(mmbbc_pkg::OP_B2T, 0, 0, 0, 32'sh8000_0000, -1), 1, k);
		add_row(mk(mmbbc_pkg::OP_B2T, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 0, k);
		// Replace the tick-zero signature with the widest bar, then saturate.
		add_row(mk(mmbbc_pkg::OP_ADD, 0, 8'd255, 4'd0, 0, 0), 1, k);
		add_row(mk(mmbbc_pkg::OP_B2T, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 0, k);
		add_row(mk(mmbbc_pkg::OP_ADD, 48'd1000, 8'd0, 4'd2, 0, 0), 1, k);
		add_row(mk(mmbbc_pkg::OP_ADD, 48'd50000, 8'd7, 4'd15, 0, 0), 1, k);
		add_row(mk(mmbbc_pkg::OP_ADD, '1, 8'd3, 4'd3, 0, 0), 1, k);
		add_row(mk(mmbbc_pkg::OP_QUERY, 48'd999, 0, 0, 0, 0), 0, k);
		add_row(mk(mmbbc_pkg::OP_QUERY, 48'd4567, 0, 0, 0, 0), 0, k);
		add_row(mk(mmbbc_pkg::OP_QUERY, 48'd123456, 0, 0, 0, 0), 0, k);
		add_row(mk(mmbbc_pkg::OP_QUERY, '1, 0, 0, 0, 0), 0, k);
		add_row(mk(mmbbc_pkg::OP_B2T, 0, 0, 0, 32'sd2, 32'sd3), 0, k);
		add_row(mk(mmbbc_pkg::OP_B2T, 0, 0, 0, 32'sd400, 32'sd9), 0, k);
		add_row(mk(mmbbc_pkg::OP_REMOVE, 48'd1000, 0, 0, 0, 0), 1, k);
		add_row(mk(mmbbc_pkg::OP_B2T, 0, 0, 0, 32'sd100, -5), 0, k);
		add_row(mk(mmbbc_pkg::OP_CLEAR, 0, 0, 0, 0, 0), 1, k);
		add_row(mk(mmbbc_pkg::OP_QUERY, 48'd7777, 0, 0, 0, 0), 0, k);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].known, dir_rows[i].want);

		write_tpq(16'd1);
		random_phase(180);
		write_tpq(16'hFFFF);
		fill_and_clear();
		random_phase(180);
		write_tpq(16'($urandom_range(2, 65534)));
		random_phase(180);
		write_tpq(mmbbc_pkg::TPQ_RESET);
		random_phase(100);
		// Closing stretch runs without gaps on either side.
		idle_on = 0;
		random_phase(100);

		drain();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
